### hw/rtl/lfw_pkg.sv
package lfw_pkg;

  localparam int LFW_MAX_WIDTH = 32;
  localparam int LFW_TAB_STOP  = 8;
  localparam int WIDTH_CAP     = 62;

  localparam int CHAR_W = 8;
  localparam int CNT_W  = 6;

  localparam logic [CHAR_W-1:0] NL_CODE  = 8'd10;
  localparam logic [CHAR_W-1:0] SP_CODE  = 8'd32;
  localparam logic [CHAR_W-1:0] TAB_CODE = 8'd9;
  localparam logic [CNT_W-1:0]  PEND_MAX = 6'd63;
  localparam logic [CNT_W-1:0]  LW_RESET = 6'd9;

  // class of a latched input beat
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_CHAR  = 2'd0;
  localparam kind_t KIND_BLANK = 2'd1;
  localparam kind_t KIND_EOL   = 2'd2;

  // source of an output beat
  typedef logic [1:0] emit_t;
  localparam emit_t EM_NONE = 2'd0;
  localparam emit_t EM_SP   = 2'd1;
  localparam emit_t EM_NL   = 2'd2;
  localparam emit_t EM_WORD = 2'd3;

  // sequencer -> datapath
  typedef struct packed {
    logic  latch_in;
    logic  use_in;
    logic  store_en;
    logic  blank_en;
    logic  emit_en;
    emit_t emit_sel;
    logic  emit_last;
    logic  loop_step;
    logic  loop_done;
    logic  col_zero;
    logic  col_add_pend;
    logic  word_done;
    logic  clr_line;
  } ctl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic             line_open;
    logic             fits;
    logic             pend_nz;
    logic             wc_nz;
    logic             wc_full;
    logic             last_sp;
    logic             last_wd;
    logic             slot_free;
    kind_t            kind;
    logic [CNT_W-1:0] wc;
    logic [CNT_W-1:0] w;
    logic [CNT_W-1:0] col;
  } sts_t;

endpackage

### hw/rtl/lfw_if.sv
interface lfw_in_if import lfw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_line;

  modport source (output valid, char_code, end_of_line, input ready);
  modport sink   (input valid, char_code, end_of_line, output ready);
endinterface

interface lfw_out_if import lfw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last_of_run;

  modport source (output valid, out_char, last_of_run, input ready);
  modport sink   (input valid, out_char, last_of_run, output ready);
endinterface

interface lfw_cfg_if import lfw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] line_width;

  modport source (output valid, line_width, input ready);
  modport sink   (input valid, line_width, output ready);
endinterface

### hw/rtl/lfw_seq.sv
module lfw_seq import lfw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              in_eol,
  output logic              in_ready,
  input  sts_t              sts,
  output ctl_t              ctl
);

  // sequencing ops
  localparam logic [2:0] SQ_DISPATCH = 3'd0;
  localparam logic [2:0] SQ_ENDWORD  = 3'd1;
  localparam logic [2:0] SQ_LOOP     = 3'd2;
  localparam logic [2:0] SQ_AFTER    = 3'd3;
  localparam logic [2:0] SQ_GOTO     = 3'd4;

  // last-beat rules
  localparam logic [1:0] LAST_NONE   = 2'd0;
  localparam logic [1:0] LAST_ALWAYS = 2'd1;
  localparam logic [1:0] LAST_WORD   = 2'd2;

  // program addresses
  localparam logic [3:0] UA_IDLE  = 4'd0;
  localparam logic [3:0] UA_ENDW  = 4'd1;
  localparam logic [3:0] UA_SP    = 4'd2;
  localparam logic [3:0] UA_NLPRE = 4'd3;
  localparam logic [3:0] UA_WORD  = 4'd4;
  localparam logic [3:0] UA_NLEND = 4'd5;
  localparam logic [3:0] UA_BLANK = 4'd6;
  localparam logic [3:0] UA_STORE = 4'd7;
  localparam logic [3:0] UA_HB    = 4'd8;

  typedef struct packed {
    logic [2:0] seq_op;
    emit_t      emit_sel;
    logic       emit_if_hw;
    logic [1:0] last_sel;
    logic       col_zero;
    logic       clr_line;
    logic       do_blank;
    logic       do_store;
    logic [3:0] target;
  } uword_t;

  function automatic uword_t rom_word(input logic [3:0] a);
    uword_t u;
    u = '0;
    u.seq_op = SQ_GOTO;
    u.target = UA_IDLE;
    case (a)
      UA_IDLE: begin
        u.seq_op = SQ_DISPATCH;
      end
      UA_ENDW: begin
        u.seq_op = SQ_ENDWORD;
      end
      UA_SP: begin
        u.seq_op   = SQ_LOOP;
        u.emit_sel = EM_SP;
        u.target   = UA_WORD;
      end
      UA_NLPRE: begin
        u.emit_sel = EM_NL;
        u.col_zero = 1'b1;
        u.target   = UA_WORD;
      end
      UA_WORD: begin
        u.seq_op   = SQ_AFTER;
        u.emit_sel = EM_WORD;
        u.last_sel = LAST_WORD;
      end
      UA_NLEND: begin
        u.emit_sel = EM_NL;
        u.last_sel = LAST_ALWAYS;
        u.clr_line = 1'b1;
      end
      UA_BLANK: begin
        u.do_blank = 1'b1;
      end
      UA_STORE: begin
        u.do_store = 1'b1;
      end
      UA_HB: begin
        u.emit_sel   = EM_NL;
        u.emit_if_hw = 1'b1;
        u.col_zero   = 1'b1;
        u.target     = UA_WORD;
      end
      default: begin
        u.seq_op = SQ_GOTO;
      end
    endcase
    return u;
  endfunction

  logic [3:0] upc_r, upc_nxt;
  uword_t     uw;
  logic       emitting;
  logic       go;
  logic       loop_last;
  logic       in_blank;

  assign in_blank = (in_char == SP_CODE) || (in_char == TAB_CODE);

  always_comb begin
    uw        = rom_word(upc_r);
    upc_nxt   = upc_r;
    ctl       = '0;
    in_ready  = 1'b0;
    emitting  = (uw.emit_sel != EM_NONE) && (!uw.emit_if_hw || sts.line_open);
    go        = !emitting || sts.slot_free;
    loop_last = (uw.emit_sel == EM_SP) ? sts.last_sp : sts.last_wd;

    ctl.emit_sel = uw.emit_sel;
    ctl.emit_en  = emitting && sts.slot_free;
    case (uw.last_sel)
      LAST_NONE:   ctl.emit_last = 1'b0;
      LAST_ALWAYS: ctl.emit_last = 1'b1;
      LAST_WORD:   ctl.emit_last = loop_last && (sts.kind != KIND_EOL);
      default:     ctl.emit_last = 1'b0;
    endcase

    if (go) begin
      ctl.col_zero = uw.col_zero;
      ctl.clr_line = uw.clr_line;
      ctl.blank_en = uw.do_blank;
      ctl.store_en = uw.do_store;
    end

    case (uw.seq_op)
      SQ_DISPATCH: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.latch_in = 1'b1;
          ctl.use_in   = 1'b1;
          if (in_eol) begin
            upc_nxt = sts.wc_nz ? UA_ENDW : UA_NLEND;
          end else if (in_blank) begin
            if (sts.wc_nz) upc_nxt = UA_ENDW;
            else           ctl.blank_en = 1'b1;
          end else begin
            if (sts.wc_full) upc_nxt = UA_HB;
            else             ctl.store_en = 1'b1;
          end
        end
      end
      SQ_ENDWORD: begin
        if (!sts.line_open) upc_nxt = UA_WORD;
        else if (!sts.fits) upc_nxt = UA_NLPRE;
        else if (sts.pend_nz) upc_nxt = UA_SP;
        else                upc_nxt = UA_WORD;
      end
      SQ_LOOP: begin
        if (go) begin
          ctl.loop_step = 1'b1;
          if (loop_last) begin
            ctl.loop_done    = 1'b1;
            ctl.col_add_pend = (uw.emit_sel == EM_SP);
            upc_nxt          = uw.target;
          end
        end
      end
      SQ_AFTER: begin
        if (go) begin
          ctl.loop_step = 1'b1;
          if (loop_last) begin
            ctl.loop_done = 1'b1;
            ctl.word_done = 1'b1;
            case (sts.kind)
              KIND_EOL:   upc_nxt = UA_NLEND;
              KIND_BLANK: upc_nxt = UA_BLANK;
              default:    upc_nxt = UA_STORE;
            endcase
          end
        end
      end
      SQ_GOTO: begin
        if (go) upc_nxt = uw.target;
      end
      default: begin
        upc_nxt = UA_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) upc_r <= UA_IDLE;
    else        upc_r <= upc_nxt;
  end

endmodule

### hw/rtl/lfw_dp.sv
module lfw_dp import lfw_pkg::*; #(
  parameter int MAX_WIDTH = LFW_MAX_WIDTH,
  parameter int TAB_STOP  = LFW_TAB_STOP
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_t              ctl,
  output sts_t              sts,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              in_eol,
  input  logic              cfg_valid,
  input  logic [CNT_W-1:0]  cfg_data,
  output logic              cfg_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int WCAP = (MAX_WIDTH > WIDTH_CAP) ? WIDTH_CAP : MAX_WIDTH;
  localparam logic [CNT_W-1:0] WCAP_V = CNT_W'(WCAP);

  logic [CNT_W-1:0]  lw_r;
  logic [CNT_W-1:0]  wc_r, wc_nxt;
  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [CNT_W-1:0]  pend_r, pend_nxt;
  logic              hw_r, hw_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [CHAR_W-1:0] char_r;
  kind_t             kind_r;
  logic [CHAR_W-1:0] rd_r;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;
  logic [CHAR_W-1:0] mem [MAX_WIDTH];

  logic [CNT_W-1:0]  w_eff;
  logic [CHAR_W-1:0] ch_sel;
  logic [6:0]        col7;
  logic [7:0]        nxt8, diff8, sum8;
  logic [CNT_W-1:0]  pend_new;
  logic              slot_free;
  logic [CHAR_W-1:0] emit_char;
  logic [7:0]        tab_lut [128];

  // next tab stop for every column a blank can start from
  for (genvar g = 0; g < 128; g++) begin : g_tab
    assign tab_lut[g] = 8'((g / TAB_STOP + 1) * TAB_STOP);
  end

  always_comb begin
    if (lw_r == '0)        w_eff = CNT_W'(1);
    else if (lw_r > WCAP_V) w_eff = WCAP_V;
    else                   w_eff = lw_r;
  end

  assign ch_sel = ctl.use_in ? in_char : char_r;

  // blank run width, measured from the end of the last word
  always_comb begin
    col7  = {1'b0, col_r} + {1'b0, pend_r};
    nxt8  = (ch_sel == TAB_CODE) ? tab_lut[col7] : {1'b0, col7} + 8'd1;
    diff8 = nxt8 - {2'b00, col_r};
    pend_new = (diff8 > {2'b00, PEND_MAX}) ? PEND_MAX : diff8[CNT_W-1:0];
  end

  assign sum8      = {2'b00, col_r} + {2'b00, pend_r} + {2'b00, wc_r};
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    sts           = '0;
    sts.line_open = hw_r;
    sts.fits      = sum8 <= {2'b00, w_eff};
    sts.pend_nz   = pend_r != '0;
    sts.wc_nz     = wc_r != '0;
    sts.wc_full   = wc_r >= w_eff;
    sts.last_sp   = ({1'b0, k_r} + 7'd1) == {1'b0, pend_r};
    sts.last_wd   = ({1'b0, k_r} + 7'd1) == {1'b0, wc_r};
    sts.slot_free = slot_free;
    sts.kind      = kind_r;
    sts.wc        = wc_r;
    sts.w         = w_eff;
    sts.col       = col_r;
  end

  always_comb begin
    wc_nxt   = wc_r;
    col_nxt  = col_r;
    pend_nxt = pend_r;
    hw_nxt   = hw_r;
    k_nxt    = k_r;
    if (ctl.store_en) wc_nxt = wc_r + CNT_W'(1);
    if (ctl.blank_en && hw_r) pend_nxt = pend_new;
    if (ctl.loop_step) k_nxt = ctl.loop_done ? '0 : k_r + CNT_W'(1);
    if (ctl.col_zero) col_nxt = '0;
    if (ctl.col_add_pend) col_nxt = col_r + pend_r;
    if (ctl.word_done) begin
      col_nxt  = col_r + wc_r;
      hw_nxt   = 1'b1;
      wc_nxt   = '0;
      pend_nxt = '0;
    end
    if (ctl.clr_line) begin
      col_nxt  = '0;
      hw_nxt   = 1'b0;
      pend_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r   <= LW_RESET;
      wc_r   <= '0;
      col_r  <= '0;
      pend_r <= '0;
      hw_r   <= 1'b0;
      k_r    <= '0;
    end else begin
      if (cfg_valid) lw_r <= cfg_data;
      wc_r   <= wc_nxt;
      col_r  <= col_nxt;
      pend_r <= pend_nxt;
      hw_r   <= hw_nxt;
      k_r    <= k_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  // latched beat
  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      char_r <= in_char;
      if (in_eol)                                         kind_r <= KIND_EOL;
      else if ((in_char == SP_CODE) || (in_char == TAB_CODE)) kind_r <= KIND_BLANK;
      else                                                kind_r <= KIND_CHAR;
    end
  end

  // word store; read data is registered from the next loop count, so it matches the current one
  always_ff @(posedge clk) begin
    if (ctl.store_en) mem[wc_r[AW-1:0]] <= ch_sel;
    rd_r <= mem[k_nxt[AW-1:0]];
  end

  always_comb begin
    case (ctl.emit_sel)
      EM_NL:   emit_char = NL_CODE;
      EM_WORD: emit_char = rd_r;
      default: emit_char = SP_CODE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_en) begin
      out_char_r <= emit_char;
      out_last_r <= ctl.emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

### hw/rtl/line_fold_word_wrap_unit.sv
// Line fold with greedy word wrap. Bytes come in one per beat; space and tab
// are blanks, every other byte (newline included) is a one-column word
// character, and an end_of_line beat closes the input line. Output lines are
// at most line_width columns (0 acts as 1, values above MAX_WIDTH or 62 are
// clamped). Tabs advance to the next multiple of TAB_STOP and come out as
// spaces. Words are buffered; a word goes out behind its blank run when both
// fit, otherwise behind a newline with the blanks dropped. A word longer than
// the line is hard-broken. last_of_run marks the final beat caused by one
// input beat. A word character that is only buffered, and a blank with no
// word buffered, are handled in the accept step alone. An end_of_line with
// no word buffered is accepted and then issues its newline. A beat that ends
// a word is accepted, then passes a decision step, the output beats, and a
// closing step for a blank (for end_of_line the closing step is its newline
// beat). A hard break is accepted, then issues the newline when the line
// already holds a word (a silent step otherwise), then the word beats and a
// closing step that stores the new character. The single output register
// moves at most one beat per cycle, and a beat held off by out_ready stalls
// the burst. Inputs stall during a burst. line_width must be written only
// while the block is idle; the block itself does not enforce this. A write
// of line_width takes effect at once.
module line_fold_word_wrap_unit import lfw_pkg::*; #(
  parameter int MAX_WIDTH = LFW_MAX_WIDTH,
  parameter int TAB_STOP  = LFW_TAB_STOP
) (
  input  logic       clk,
  input  logic       rst_n,
  lfw_in_if.sink     in_bus,
  lfw_out_if.source  out_bus,
  lfw_cfg_if.sink    cfg_bus
);

  ctl_t ctl;  // control word decoded for this cycle
  sts_t sts;  // datapath flags for branching

  // microcoded sequencer: step counter, control ROM, conditional jumps
  lfw_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_char  (in_bus.char_code),
    .in_eol   (in_bus.end_of_line),
    .in_ready (in_bus.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // word store, line counters, tab table and output register
  lfw_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .TAB_STOP  (TAB_STOP)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_char   (in_bus.char_code),
    .in_eol    (in_bus.end_of_line),
    .cfg_valid (cfg_bus.valid),
    .cfg_data  (cfg_bus.line_width),
    .cfg_ready (cfg_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_char  (out_bus.out_char),
    .out_last  (out_bus.last_of_run)
  );

  // an end-of-line beat always produces output, so the sequencer leaves dispatch
  a_eol_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.valid && in_bus.ready && in_bus.end_of_line |=> !in_bus.ready)
    else $error("eol beat did not start a flush");

  // buffered word stays within the store; effective width is never zero
  a_wc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (sts.w != '0) && (sts.wc <= CNT_W'(MAX_WIDTH)))
    else $error("word count above store depth");

  // an empty line sits at column zero
  a_col_empty_line: assert property (@(posedge clk) disable iff (!rst_n)
    !sts.line_open |-> sts.col == '0)
    else $error("column nonzero on a line without words");

  // a full buffer forces a hard break before the new character is taken
  a_hard_break: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.valid && in_bus.ready && !in_bus.end_of_line && sts.wc_full &&
    (in_bus.char_code != SP_CODE) && (in_bus.char_code != TAB_CODE)
    |=> !in_bus.ready)
    else $error("full word buffer did not break");

endmodule

### dv/testbench.sv
// Testbench for line_fold_word_wrap_unit.
// Text bytes go in one beat at a time; folded text comes out one byte per
// beat. A local fold model runs on every accepted input beat and queues the
// bytes it predicts. Every output beat is checked against the oldest one.
module testbench;
  import lfw_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  // A blank or buffered char gives no beat, but the block may still be busy
  // after the last beat of a burst.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STEP_CAP      = 64;

  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic              last;
  } fold_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  lfw_in_if  in_bus ();
  lfw_out_if out_bus ();
  lfw_cfg_if cfg_bus ();

  line_fold_word_wrap_unit i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Fold model state. Mirrors the block: buffered word, column, blank run
  // width behind the last word, and whether the line holds a word yet.
  // ---------------------------------------------------------------------
  logic [CHAR_W-1:0] word_buf [LFW_MAX_WIDTH];
  int unsigned       word_len;
  int unsigned       col_pos;
  int unsigned       blank_run;
  bit                line_started;
  logic [CNT_W-1:0]  width_reg;

  logic [CHAR_W-1:0] step_chars [$];   // bytes caused by the current beat
  fold_beat_t        folded_text_q [$]; // bytes still owed by the block

  int unsigned beats_sent;
  int unsigned cycle_count;
  int unsigned fail_count;
  bit          sender_gaps;
  bit          receiver_stalls;

  // Effective width: 0 acts as 1, clamp to MAX_WIDTH and the hard cap.
  function automatic int unsigned wrap_limit();
    int unsigned w;
    w = 32'(width_reg);
    if (w == 0) w = 1;
    if (w > LFW_MAX_WIDTH) w = LFW_MAX_WIDTH;
    if (w > WIDTH_CAP) w = WIDTH_CAP;
    return w;
  endfunction

  function automatic void put_char(logic [CHAR_W-1:0] c);
    if (step_chars.size() < STEP_CAP) step_chars.push_back(c);
  endfunction

  function automatic void put_word();
    for (int unsigned k = 0; k < word_len && k < LFW_MAX_WIDTH; k++) put_char(word_buf[k]);
    col_pos += word_len;
    line_started = 1'b1;
    word_len = 0;
    blank_run = 0;
  endfunction

  // Word ended by a blank or end of line: it goes behind its blank run if
  // both fit, else behind a newline with the blanks dropped.
  function automatic void close_word(int unsigned w);
    if (word_len == 0) return;
    if (line_started) begin
      if (col_pos + blank_run + word_len <= w) begin
        for (int unsigned k = 0; k < blank_run; k++) put_char(SP_CODE);
        col_pos += blank_run;
      end else begin
        put_char(NL_CODE);
        col_pos = 0;
      end
    end else begin
      col_pos = 0;
    end
    put_word();
  endfunction

  function automatic void fold_char(logic [CHAR_W-1:0] code, logic eol);
    int unsigned w;
    int unsigned stop_col;
    int unsigned adv;
    fold_beat_t  b;
    w = wrap_limit();
    step_chars.delete();
    if (eol) begin
      close_word(w);
      put_char(NL_CODE);
      col_pos = 0;
      line_started = 1'b0;
      blank_run = 0;
    end else if (code == SP_CODE || code == TAB_CODE) begin
      close_word(w);
      // leading blanks on a line are dropped
      if (line_started) begin
        stop_col = col_pos + blank_run;
        if (code == TAB_CODE) adv = (stop_col / LFW_TAB_STOP + 1) * LFW_TAB_STOP;
        else adv = stop_col + 1;
        adv -= col_pos;
        blank_run = (adv > 32'(PEND_MAX)) ? 32'(PEND_MAX) : adv;
      end
    end else begin
      // hard break: buffer full, flush it before taking the new char
      if (word_len >= w) begin
        if (line_started) put_char(NL_CODE);
        col_pos = 0;
        put_word();
      end
      if (word_len < LFW_MAX_WIDTH) begin
        word_buf[word_len] = code;
        word_len++;
      end
    end
    foreach (step_chars[i]) begin
      b.chr  = step_chars[i];
      b.last = (i == step_chars.size() - 1);
      folded_text_q.push_back(b);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Input side. Valid changes only at the falling edge; a gap of zero keeps
  // valid high straight into the next beat.
  // ---------------------------------------------------------------------
  task automatic send_beat(logic [CHAR_W-1:0] code, logic eol);
    int unsigned gap;
    gap = sender_gaps ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.char_code   <= code;
    in_bus.end_of_line <= eol;
    do @(posedge clk); while (!in_bus.ready);
    fold_char(code, eol);
    beats_sent++;
  endtask

  // Stop sending, let every owed byte arrive, then let the block settle.
  task automatic wait_drained();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (folded_text_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_line_width(logic [CNT_W-1:0] value);
    wait_drained();
    cfg_bus.valid      <= 1'b1;
    cfg_bus.line_width <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    width_reg = value;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] word_byte();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(0, 255)); while (c == SP_CODE || c == TAB_CODE);
    return c;
  endfunction

  // Mostly well-formed text: words (some longer than the line) with short
  // blank runs, line ends, now and then a long blank run that saturates the
  // pending width; the rest is raw noise bytes.
  task automatic send_text(int unsigned count);
    int unsigned start;
    int unsigned w;
    int unsigned len;
    int unsigned run;
    int unsigned pick;
    start = beats_sent;
    while (beats_sent - start < count) begin
      w = wrap_limit();
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_beat(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else begin
        if ($urandom_range(0, 9) == 0) len = $urandom_range(w + 1, 2 * w + 2);
        else len = $urandom_range(1, w);
        repeat (len) send_beat(word_byte(), 1'b0);
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          send_beat(CHAR_W'($urandom_range(0, 255)), 1'b1);
        end else begin
          run = (pick < 18) ? $urandom_range(20, 70) : $urandom_range(1, 3);
          repeat (run) send_beat($urandom_range(0, 1) ? TAB_CODE : SP_CODE, 1'b0);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------

  // Reset width of 9: word chars at the byte extremes, a newline byte that
  // counts as a word char, space and tab between words, trailing blank.
  task automatic test_reset_width_text();
    send_beat("a", 1'b0);
    send_beat("b", 1'b0);
    send_beat(SP_CODE, 1'b0);
    send_beat(TAB_CODE, 1'b0);
    send_beat(NL_CODE, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(SP_CODE, 1'b0);
    send_beat(8'h00, 1'b1);
  endtask

  // Blank line, then leading blanks dropped before an empty line end.
  task automatic test_blank_lines();
    send_beat(8'hFF, 1'b1);
    send_beat(SP_CODE, 1'b0);
    send_beat(TAB_CODE, 1'b0);
    send_beat(SP_CODE, 1'b1);
  endtask

  // Narrowest line: every word char after the first in a word forces a hard break.
  task automatic test_hard_break();
    write_line_width(6'd1);
    send_beat("x", 1'b0);
    send_beat("y", 1'b0);
    send_beat("z", 1'b0);
    send_beat(SP_CODE, 1'b0);
    send_beat("q", 1'b0);
    send_beat(SP_CODE, 1'b1);
  endtask

  // Sender holds off mid-word until every owed byte is out, then resumes.
  task automatic test_drain_mid_word();
    write_line_width(LW_RESET);
    send_beat("a", 1'b0);
    send_beat("b", 1'b0);
    send_beat(SP_CODE, 1'b0);
    send_beat("c", 1'b0);
    wait_drained();
    send_beat("d", 1'b0);
    send_beat(TAB_CODE, 1'b0);
    send_beat(SP_CODE, 1'b1);
  endtask

  // Random text over a range of widths, the extremes included (0 acts as 1,
  // 63 clamps to MAX_WIDTH). One phase runs with no idling on either side.
  task automatic test_random_widths();
    logic [CNT_W-1:0] widths [8];
    widths[0] = 6'd0;
    widths[1] = 6'd1;
    widths[2] = 6'd32;
    widths[3] = 6'd63;
    widths[4] = LW_RESET;
    widths[5] = CNT_W'($urandom_range(2, 31));
    widths[6] = CNT_W'($urandom_range(33, 62));
    widths[7] = CNT_W'($urandom_range(0, 63));
    foreach (widths[i]) begin
      write_line_width(widths[i]);
      sender_gaps     = (i != 4);
      receiver_stalls = (i != 4);
      send_text(50);
    end
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // Output side: ready drawn per beat, changed at the falling edge.
  // ---------------------------------------------------------------------
  initial begin : drive_out_ready
    int unsigned stall;
    out_bus.ready = 1'b0;
    forever begin
      stall = receiver_stalls ? $urandom_range(0, 5) : 0;
      @(negedge clk);
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
    end
  end

  // Every accepted output beat is compared with the oldest owed byte.
  always @(posedge clk) begin : check_folded_text
    fold_beat_t exp_beat;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (folded_text_q.size() == 0) begin
        $error("unexpected output beat: out_char %0d last_of_run %0b",
               out_bus.out_char, out_bus.last_of_run);
        fail_count++;
      end else begin
        exp_beat = folded_text_q.pop_front();
        if (out_bus.out_char !== exp_beat.chr) begin
          $error("out_char mismatch: expected %0d, got %0d", exp_beat.chr, out_bus.out_char);
          fail_count++;
        end
        if (out_bus.last_of_run !== exp_beat.last) begin
          $error("last_of_run mismatch: expected %0b, got %0b",
                 exp_beat.last, out_bus.last_of_run);
          fail_count++;
        end
      end
    end
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.char_code   = '0;
    in_bus.end_of_line = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.line_width = '0;
    word_len           = 0;
    col_pos            = 0;
    blank_run          = 0;
    line_started       = 1'b0;
    width_reg          = LW_RESET;
    beats_sent         = 0;
    cycle_count        = 0;
    fail_count         = 0;
    sender_gaps        = 1'b1;
    receiver_stalls    = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_width_text();
    test_blank_lines();
    test_hard_break();
    test_drain_mid_word();
    test_random_widths();
    wait_drained();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
